[rtl/ccc_pkg.sv]
`default_nettype none
package ccc_pkg;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    localparam cal_t CAL_RESET = '{
        year:    14'd2022,
        month:   4'd4,
        day:     5'd30,
        weekday: 3'd6,
        hour:    5'd23,
        minute:  6'd59,
        second:  6'd40
    };

    localparam logic [5:0]  SEC_TOP     = 6'd59;
    localparam logic [5:0]  MIN_TOP     = 6'd59;
    localparam logic [4:0]  HOUR_TOP    = 5'd23;
    localparam logic [2:0]  WEEKDAY_TOP = 3'd6;
    localparam logic [3:0]  MONTH_TOP   = 4'd12;
    localparam logic [13:0] YEAR_TOP    = 14'd9999;

    // year / 100 as (year * YEAR_RECIP) >> YEAR_SHIFT, exact for any 14-bit year
    localparam int          YEAR_SHIFT  = 22;
    localparam logic [15:0] YEAR_RECIP  = 16'd41944;
    localparam int          YEAR_QW     = 8;

    function automatic logic [4:0] month_len(input logic [3:0] month,
                                             input logic [13:0] year);
        logic [4:0] len;
        len = 5'd31;
        unique case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // tens and units of a value below 100, thresholds compared in parallel
    function automatic logic [7:0] two_digits(input logic [6:0] value);
        logic [3:0] tens;
        logic [6:0] units;
        tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (value >= 7'(k * 10)) begin
                tens = 4'(k);
            end
        end
        units = value - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
        return {tens, units[3:0]};
    endfunction

endpackage
`default_nettype wire

[rtl/ccc_tick.sv]
`default_nettype none
module ccc_tick
    import ccc_pkg::*;
(
    input  cal_t cur,
    input  logic load,
    input  cal_t load_val,
    output cal_t nxt
);

    logic [5:0]  sec_inc;
    logic [5:0]  min_inc;
    logic [4:0]  hour_inc;
    logic [2:0]  wd_inc;
    logic [5:0]  day_inc;
    logic [13:0] year_inc;
    logic        sec_wrap;
    logic        min_wrap;
    logic        hour_wrap;
    logic        day_wrap;
    logic        month_wrap;

    always_comb begin
        sec_inc    = cur.second + 6'd1;
        min_inc    = cur.minute + 6'd1;
        hour_inc   = cur.hour + 5'd1;
        wd_inc     = cur.weekday + 3'd1;
        day_inc    = {1'b0, cur.day} + 6'd1;
        year_inc   = (cur.year >= YEAR_TOP) ? 14'd0 : cur.year + 14'd1;
        // width wrap to zero carries as well
        sec_wrap   = (sec_inc > SEC_TOP) || (sec_inc == 6'd0);
        min_wrap   = (min_inc > MIN_TOP) || (min_inc == 6'd0);
        hour_wrap  = (hour_inc > HOUR_TOP) || (hour_inc == 5'd0);
        day_wrap   = day_inc > {1'b0, month_len(cur.month, cur.year)};
        month_wrap = cur.month >= MONTH_TOP;
    end

    always_comb begin
        nxt = cur;
        if (load) begin
            nxt = load_val;
        end else begin
            nxt.second = sec_wrap ? 6'd0 : sec_inc;
            if (sec_wrap) begin
                nxt.minute = min_wrap ? 6'd0 : min_inc;
                if (min_wrap) begin
                    nxt.hour = hour_wrap ? 5'd0 : hour_inc;
                    if (hour_wrap) begin
                        nxt.weekday = (wd_inc > WEEKDAY_TOP) ? 3'd0 : wd_inc;
                        nxt.day     = day_wrap ? 5'd1 : day_inc[4:0];
                        if (day_wrap) begin
                            if (month_wrap) begin
                                nxt.month = 4'd1;
                                nxt.year  = year_inc;
                            end else begin
                                nxt.month = cur.month + 4'd1;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/ccc_digits.sv]
`default_nettype none
module ccc_digits
    import ccc_pkg::*;
(
    input  cal_t                cal,
    input  logic [YEAR_QW-1:0]  year_q,
    output logic [47:0]         digits
);

    logic [13:0] year_hund;
    logic [13:0] year_rem;

    always_comb begin
        year_hund = 14'({6'b0, year_q} * 14'd100);
        year_rem  = cal.year - year_hund;
        digits = {two_digits(year_rem[6:0]),
                  two_digits({3'b000, cal.month}),
                  two_digits({2'b00, cal.day}),
                  two_digits({2'b00, cal.hour}),
                  two_digits({1'b0, cal.minute}),
                  two_digits({1'b0, cal.second})};
    end

endmodule
`default_nettype wire

[rtl/calendar_clock_counter.sv]
// calendar_clock_counter: real-time-clock calendar with a display digit output
//
// input channel (s_valid/s_ready): each transfer is a one-second tick
// (s_kind = 0) or a load of the full date and time from the s_load_* ports
// (s_kind = 1). the calendar advances at the input transfer, so the next
// item sees the updated date at once.
// result channel (m_valid/m_ready): one result per input item, in order:
// the date and time after that item plus twelve packed decimal digits
// (year mod 100, month, day, hour, minute, second).
// throughput: one item per cycle while m_ready is high. latency: three
// registers (tick register, year quotient register, digit and output
// register); m_valid rises once an item has passed through all three.
// when m_ready is low the result register holds and the stages behind it
// fill; s_ready drops only once all three stages are full.
// reset (aresetn low, synchronous) empties the pipeline and sets the
// calendar to 2022-04-30, Saturday, 23:59:40.
`default_nettype none
module calendar_clock_counter
    import ccc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [13:0] s_load_year,
    input  wire logic [3:0]  s_load_month,
    input  wire logic [4:0]  s_load_day,
    input  wire logic [2:0]  s_load_weekday,
    input  wire logic [4:0]  s_load_hour,
    input  wire logic [5:0]  s_load_minute,
    input  wire logic [5:0]  s_load_second,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [13:0]      m_year,
    output logic [3:0]       m_month,
    output logic [4:0]       m_day,
    output logic [2:0]       m_weekday,
    output logic [4:0]       m_hour,
    output logic [5:0]       m_minute,
    output logic [5:0]       m_second,
    output logic [47:0]      m_display_digits
);

    cal_t               cal_reg;
    cal_t               cal_next;
    cal_t               load_val;
    cal_t               a_cal_reg;
    cal_t               b_cal_reg;
    cal_t               m_cal_reg;
    logic               a_valid_reg;
    logic               b_valid_reg;
    logic               m_valid_reg;
    logic               a_valid_next;
    logic               b_valid_next;
    logic               m_valid_next;
    logic [YEAR_QW-1:0] b_q_reg;
    logic [YEAR_QW-1:0] b_q_next;
    logic [29:0]        year_prod;
    logic [47:0]        m_digits_reg;
    logic [47:0]        m_digits_next;
    logic               s_xfer;
    logic               a_load;
    logic               b_load;
    logic               c_load;

    assign load_val = '{
        year:    s_load_year,
        month:   s_load_month,
        day:     s_load_day,
        weekday: s_load_weekday,
        hour:    s_load_hour,
        minute:  s_load_minute,
        second:  s_load_second
    };

    ccc_tick u_tick (
        .cur      (cal_reg),
        .load     (s_kind),
        .load_val (load_val),
        .nxt      (cal_next)
    );

    // each stage takes a new entry when empty or when its entry moves on
    assign c_load  = !m_valid_reg || m_ready;
    assign b_load  = !b_valid_reg || c_load;
    assign a_load  = !a_valid_reg || b_load;
    assign s_ready = a_load;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        a_valid_next = a_load ? s_xfer : a_valid_reg;
        b_valid_next = b_load ? a_valid_reg : b_valid_reg;
        m_valid_next = c_load ? b_valid_reg : m_valid_reg;
        year_prod    = 30'(a_cal_reg.year) * 30'(YEAR_RECIP);
        b_q_next     = year_prod[YEAR_SHIFT +: YEAR_QW];
    end

    ccc_digits u_digits (
        .cal    (b_cal_reg),
        .year_q (b_q_reg),
        .digits (m_digits_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg     <= CAL_RESET;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                cal_reg <= cal_next;
            end
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            a_cal_reg <= cal_next;
        end
        if (b_load && a_valid_reg) begin
            b_cal_reg <= a_cal_reg;
            b_q_reg   <= b_q_next;
        end
        if (c_load && b_valid_reg) begin
            m_cal_reg    <= b_cal_reg;
            m_digits_reg <= m_digits_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_year           = m_cal_reg.year;
    assign m_month          = m_cal_reg.month;
    assign m_day            = m_cal_reg.day;
    assign m_weekday        = m_cal_reg.weekday;
    assign m_hour           = m_cal_reg.hour;
    assign m_minute         = m_cal_reg.minute;
    assign m_second         = m_cal_reg.second;
    assign m_display_digits = m_digits_reg;

endmodule
`default_nettype wire

[rtl/ccc_checker.sv]
`default_nettype none
module ccc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [13:0] m_year,
    input wire logic [3:0]  m_month,
    input wire logic [4:0]  m_day,
    input wire logic [4:0]  m_hour,
    input wire logic [5:0]  m_minute,
    input wire logic [5:0]  m_second,
    input wire logic [47:0] m_display_digits
);

    // pipeline is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_display_digits)
            && $stable(m_second) && $stable(m_year))
        else $error("result changed while stalled");

    // time digits agree with the time fields
    a_time_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            ({4'b0, m_display_digits[7:4]} * 8'd10
                + {4'b0, m_display_digits[3:0]} == {2'b0, m_second})
            && ({4'b0, m_display_digits[15:12]} * 8'd10
                + {4'b0, m_display_digits[11:8]} == {2'b0, m_minute})
            && ({4'b0, m_display_digits[23:20]} * 8'd10
                + {4'b0, m_display_digits[19:16]} == {3'b0, m_hour}))
        else $error("time digits do not match time fields");

    // date digits agree with the date fields
    a_date_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            ({4'b0, m_display_digits[31:28]} * 8'd10
                + {4'b0, m_display_digits[27:24]} == {3'b0, m_day})
            && ({4'b0, m_display_digits[39:36]} * 8'd10
                + {4'b0, m_display_digits[35:32]} == {4'b0, m_month}))
        else $error("date digits do not match date fields");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (.*);
`default_nettype wire

[sim/calendar_clock_counter_test.sv]
`default_nettype none
module calendar_clock_counter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ccc_pkg::*;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;
    localparam int   RANDOM_ITEMS = 1150;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   DRAIN_CYCLES = 10;
    localparam int   HOLD_MARK = 300;
    localparam int   HOLD_CYCLES = 150;

    typedef struct {
        logic kind;
        cal_t load;
    } clock_item_t;

    typedef struct {
        cal_t        cal;
        logic [47:0] digits;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = KIND_TICK;
    logic [13:0] s_load_year = '0;
    logic [3:0]  s_load_month = '0;
    logic [4:0]  s_load_day = '0;
    logic [2:0]  s_load_weekday = '0;
    logic [4:0]  s_load_hour = '0;
    logic [5:0]  s_load_minute = '0;
    logic [5:0]  s_load_second = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [13:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day;
    logic [2:0]  m_weekday;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;
    logic [47:0] m_display_digits;

    clock_item_t pending_items[$];
    reading_t    expected_readings[$];
    cal_t        calendar_now = CAL_RESET;
    int          total_items = 0;
    int          items_accepted = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          s_took = 1'b0;

    calendar_clock_counter dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_load_year      (s_load_year),
        .s_load_month     (s_load_month),
        .s_load_day       (s_load_day),
        .s_load_weekday   (s_load_weekday),
        .s_load_hour      (s_load_hour),
        .s_load_minute    (s_load_minute),
        .s_load_second    (s_load_second),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_year           (m_year),
        .m_month          (m_month),
        .m_day            (m_day),
        .m_weekday        (m_weekday),
        .m_hour           (m_hour),
        .m_minute         (m_minute),
        .m_second         (m_second),
        .m_display_digits (m_display_digits)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // february follows the four-year rule only, anything unknown is a long month
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic [13:0] year);
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            4'd2:                    return (year % 4 == 0) ? 5'd29 : 5'd28;
            default:                 return 5'd31;
        endcase
    endfunction

    function automatic cal_t advance_second(input cal_t c);
        cal_t       n;
        logic [5:0] next_day;
        n = c;
        n.second = c.second + 6'd1;
        if (n.second <= SEC_TOP && n.second != 6'd0) return n;
        n.second = 6'd0;
        n.minute = c.minute + 6'd1;
        if (n.minute <= MIN_TOP && n.minute != 6'd0) return n;
        n.minute = 6'd0;
        n.hour = c.hour + 5'd1;
        if (n.hour <= HOUR_TOP && n.hour != 5'd0) return n;
        n.hour = 5'd0;
        n.weekday = c.weekday + 3'd1;
        if (n.weekday > WEEKDAY_TOP) n.weekday = 3'd0;
        next_day = {1'b0, c.day} + 6'd1;
        if (next_day <= {1'b0, month_days(c.month, c.year)}) begin
            n.day = next_day[4:0];
            return n;
        end
        n.day = 5'd1;
        if (c.month >= MONTH_TOP) begin
            n.month = 4'd1;
            n.year = (c.year >= YEAR_TOP) ? 14'd0 : c.year + 14'd1;
        end else begin
            n.month = c.month + 4'd1;
        end
        return n;
    endfunction

    function automatic logic [7:0] decimal_pair(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic reading_t make_reading(input cal_t c);
        reading_t r;
        r.cal = c;
        r.digits = {decimal_pair(c.year % 100), decimal_pair(c.month), decimal_pair(c.day),
                    decimal_pair(c.hour), decimal_pair(c.minute), decimal_pair(c.second)};
        return r;
    endfunction

    function automatic void compare_field(input string label, input logic [47:0] want,
                                          input logic [47:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    // sender idles 19 then 65 then 0 percent, the receiver 65 then 19 then 0 percent
    function automatic int idle_pct(input int done_count, input bit receiver);
        int phase;
        if (total_items == 0) return 0;
        phase = done_count * 3 / total_items;
        case (phase)
            0:       return receiver ? 65 : 19;
            1:       return receiver ? 19 : 65;
            default: return 0;
        endcase
    endfunction

    task automatic push_tick();
        clock_item_t it;
        it.kind = KIND_TICK;
        it.load = '0;
        pending_items.push_back(it);
    endtask

    task automatic push_load(input int y, input int mo, input int d, input int w,
                             input int h, input int mi, input int s);
        clock_item_t it;
        it.kind = KIND_LOAD;
        it.load.year = 14'(y);
        it.load.month = 4'(mo);
        it.load.day = 5'(d);
        it.load.weekday = 3'(w);
        it.load.hour = 5'(h);
        it.load.minute = 6'(mi);
        it.load.second = 6'(s);
        pending_items.push_back(it);
    endtask

    task automatic push_random_noise();
        clock_item_t it;
        it.kind = 1'($urandom);
        it.load.year = 14'($urandom);
        it.load.month = 4'($urandom);
        it.load.day = 5'($urandom);
        it.load.weekday = 3'($urandom);
        it.load.hour = 5'($urandom);
        it.load.minute = 6'($urandom);
        it.load.second = 6'($urandom);
        pending_items.push_back(it);
    endtask

    // a sane date, often close to some rollover, then a run of ticks
    task automatic push_rollover_run();
        int y;
        int mo;
        int len;
        int d;
        int runs;
        mo = $urandom_range(1, 12);
        case ($urandom_range(0, 4))
            0:       y = $urandom_range(0, 9999);
            1:       y = $urandom_range(9996, 9999);
            2:       y = $urandom_range(0, 2499) * 4;
            3:       y = $urandom_range(1990, 2100);
            default: begin
                y = 9999;
                mo = 12;
            end
        endcase
        len = month_days(4'(mo), 14'(y));
        d = ($urandom_range(0, 2) == 0) ? $urandom_range(1, len) : len - $urandom_range(0, 1);
        push_load(y, mo, d, $urandom_range(0, 6),
                  $urandom_range(0, 1) ? 23 : $urandom_range(0, 23),
                  $urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
                  $urandom_range(0, 1) ? $urandom_range(45, 59) : $urandom_range(0, 59));
        runs = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
        repeat (runs) push_tick();
    endtask

    // driver: offers the next item once the previous one has been taken
    always @(negedge aclk) begin : driver
        clock_item_t it;
        if (aresetn && (!s_valid || s_took)) begin
            if (pending_items.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct(items_accepted, 1'b0)) begin
                it = pending_items.pop_front();
                s_kind <= it.kind;
                s_load_year <= it.load.year;
                s_load_month <= it.load.month;
                s_load_day <= it.load.day;
                s_load_weekday <= it.load.weekday;
                s_load_hour <= it.load.hour;
                s_load_minute <= it.load.minute;
                s_load_second <= it.load.second;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    always @(negedge aclk) begin : receiver
        int  hold_left;
        bit  hold_done;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_MARK) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= idle_pct(results_seen, 1'b1));
        end
    end

    always @(posedge aclk) begin : monitor
        reading_t want;
        cal_t     got;
        cal_t     loaded;
        s_took = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                s_took = 1'b1;
                items_accepted++;
                if (s_kind == KIND_LOAD) begin
                    loaded.year = s_load_year;
                    loaded.month = s_load_month;
                    loaded.day = s_load_day;
                    loaded.weekday = s_load_weekday;
                    loaded.hour = s_load_hour;
                    loaded.minute = s_load_minute;
                    loaded.second = s_load_second;
                    calendar_now = loaded;
                end else begin
                    calendar_now = advance_second(calendar_now);
                end
                expected_readings.push_back(make_reading(calendar_now));
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_readings.size() == 0) begin
                    $display({"%0t: result transfer with nothing expected, expected none, ",
                              "actual %0d-%0d-%0d %0d:%0d:%0d"},
                             $time, m_year, m_month, m_day, m_hour, m_minute, m_second);
                    mismatch_count++;
                end else begin
                    want = expected_readings.pop_front();
                    got = want.cal;
                    compare_field("year", 48'(want.cal.year), 48'(m_year));
                    compare_field("month", 48'(want.cal.month), 48'(m_month));
                    compare_field("day", 48'(want.cal.day), 48'(m_day));
                    compare_field("weekday", 48'(want.cal.weekday), 48'(m_weekday));
                    compare_field("hour", 48'(want.cal.hour), 48'(m_hour));
                    compare_field("minute", 48'(want.cal.minute), 48'(m_minute));
                    compare_field("second", 48'(got.second), 48'(m_second));
                    compare_field("display_digits", want.digits, m_display_digits);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        // first tick straight from the reset date
        push_tick();
        // end of april into may, weekday wrapping saturday to sunday
        push_load(2022, 4, 30, 6, 23, 59, 59);
        push_tick();
        // last second of year 9999 wraps to year 0
        push_load(9999, 12, 31, 5, 23, 59, 59);
        push_tick();
        // leap february goes to the 29th, then into march
        push_load(2024, 2, 28, 3, 23, 59, 59);
        push_tick();
        push_load(2024, 2, 29, 4, 23, 59, 59);
        push_tick();
        // common february
        push_load(2023, 2, 28, 2, 23, 59, 59);
        push_tick();
        push_load(2021, 1, 31, 0, 23, 59, 59);
        push_tick();
        // every load field at its width limit
        push_load(16383, 15, 31, 7, 31, 63, 63);
        push_tick();
        push_load(0, 0, 0, 0, 0, 0, 0);
        push_tick();
        // hour above its top, month 13, weekday 7
        push_load(2000, 13, 31, 7, 31, 59, 59);
        push_tick();
        // day beyond a thirty-day month
        push_load(2010, 4, 31, 1, 23, 59, 59);
        push_tick();
        // month 0 counted as a long month
        push_load(2011, 0, 31, 2, 23, 59, 59);
        push_tick();
        // year above 9999 with a year carry
        push_load(12000, 12, 31, 3, 23, 59, 59);
        push_tick();
        while (pending_items.size() < RANDOM_ITEMS + 25) begin
            if ($urandom_range(0, 99) < 15) begin
                push_random_noise();
            end else begin
                push_rollover_run();
            end
        end
        total_items = pending_items.size();

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid || expected_readings.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

[calendar_clock_counter.f]
rtl/ccc_pkg.sv
rtl/ccc_tick.sv
rtl/ccc_digits.sv
rtl/calendar_clock_counter.sv
rtl/ccc_checker.sv
sim/calendar_clock_counter_test.sv
